@@ sv/cell_balance_selector_assert.svh @@
// Assertion macros for the checker file of the cell balance selector.
`ifndef CELL_BALANCE_SELECTOR_ASSERT_SVH
`define CELL_BALANCE_SELECTOR_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define CBS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("cell balance selector check failed");

// Property checked at every clock edge, reset included.
`define CBS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("cell balance selector check failed");

`endif

@@ sv/cbs_pkg.sv @@
// Package with the types, widths and constants of the cell balance selector.
package cbs_pkg;

  // Field widths.
  localparam int unsigned MV_W     = 13;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned BYTE_W   = 5;
  localparam int unsigned MASK_W   = 3 * BYTE_W;
  localparam int unsigned CFG_IDX_W = 1;

  // Default number of cells in a scan.
  localparam int unsigned NUM_CELLS_DEFAULT = 15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CELL_FLOOR   = 1'd1;

  // Register reset values.
  localparam logic [MV_W-1:0] SPREAD_THRESHOLD_RESET = 13'd30;
  localparam logic [MV_W-1:0] MIN_CELL_FLOOR_RESET   = 13'd3000;

  // One cell sample.
  typedef struct packed {
    logic [MV_W-1:0] cell_mv;
    logic            last_cell;
    logic            inhibit;
  } in_item_t;

  // One end-of-scan decision.
  typedef struct packed {
    logic              write_regs;
    logic [BYTE_W-1:0] bal_low;
    logic [BYTE_W-1:0] bal_mid;
    logic [BYTE_W-1:0] bal_high;
    logic              bal_enable;
    logic [IDX_W-1:0]  max_cell_index;
    logic [MV_W-1:0]   spread_mv;
  } out_item_t;

endpackage

@@ sv/cbs_scan.sv @@
// Scan tracker: running max and min over one scan and the balancing decision.
module cbs_scan #(
  parameter int unsigned NUM_CELLS = cbs_pkg::NUM_CELLS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  cbs_pkg::in_item_t         item,
  input  logic [cbs_pkg::MV_W-1:0]  spread_threshold_mv,
  input  logic [cbs_pkg::MV_W-1:0]  min_cell_floor_mv,
  output cbs_pkg::out_item_t        result
);

  localparam int unsigned POS_W = $clog2(NUM_CELLS + 1);

  logic [cbs_pkg::MV_W-1:0]   running_max;
  logic [cbs_pkg::IDX_W-1:0]  running_max_index;
  logic [cbs_pkg::MV_W-1:0]   running_min;
  logic [POS_W-1:0]           cell_position;
  logic [cbs_pkg::MASK_W-1:0] last_mask;

  logic [cbs_pkg::MV_W-1:0]   running_max_next;
  logic [cbs_pkg::IDX_W-1:0]  running_max_index_next;
  logic [cbs_pkg::MV_W-1:0]   running_min_next;
  logic [POS_W-1:0]           cell_position_next;
  logic [cbs_pkg::MASK_W-1:0] mask;
  logic [cbs_pkg::MV_W-1:0]   spread;
  logic                       take_cell;
  logic                       first_cell;
  logic                       on;
  logic                       wr;

  // Fold the new cell into the running values; cells past the count are ignored.
  always_comb begin
    take_cell              = cell_position < POS_W'(NUM_CELLS);
    first_cell             = cell_position == '0;
    running_max_next       = running_max;
    running_max_index_next = running_max_index;
    running_min_next       = running_min;
    cell_position_next     = cell_position;
    if (take_cell) begin
      cell_position_next = cell_position + 1'b1;
      if (first_cell) begin
        running_max_next       = item.cell_mv;
        running_min_next       = item.cell_mv;
        running_max_index_next = '0;
      end else begin
        if (item.cell_mv > running_max) begin
          running_max_next       = item.cell_mv;
          running_max_index_next = cbs_pkg::IDX_W'(cell_position);
        end
        if (item.cell_mv != '0 && item.cell_mv < running_min) begin
          running_min_next = item.cell_mv;
        end
      end
    end
  end

  // Decide on balancing and build the one-hot bleed mask of the highest cell.
  always_comb begin
    spread = running_max_next - running_min_next;
    on     = !item.inhibit && (spread > spread_threshold_mv)
             && (running_min_next > min_cell_floor_mv);
    mask   = on ? (cbs_pkg::MASK_W'(1) << running_max_index_next) : '0;
    wr     = on ? (mask != last_mask) : 1'b1;
    result.write_regs     = wr;
    result.bal_low        = mask[cbs_pkg::BYTE_W-1:0];
    result.bal_mid        = mask[2*cbs_pkg::BYTE_W-1:cbs_pkg::BYTE_W];
    result.bal_high       = mask[3*cbs_pkg::BYTE_W-1:2*cbs_pkg::BYTE_W];
    result.bal_enable     = on;
    result.max_cell_index = running_max_index_next;
    result.spread_mv      = spread;
  end

  // Running state; the final cell of a scan clears it and stores the mask.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_max       <= '0;
      running_max_index <= '0;
      running_min       <= '0;
      cell_position     <= '0;
      last_mask         <= '0;
    end else if (take) begin
      if (item.last_cell) begin
        running_max       <= '0;
        running_max_index <= '0;
        running_min       <= '0;
        cell_position     <= '0;
        last_mask         <= mask;
      end else begin
        running_max       <= running_max_next;
        running_max_index <= running_max_index_next;
        running_min       <= running_min_next;
        cell_position     <= cell_position_next;
      end
    end
  end

endmodule

@@ sv/cell_balance_selector.sv @@
// Top level of the cell balance selector: handshakes, registers and scan tracker.
//
// Cells of one scan arrive on the input channel (in_valid/in_ready/in_data),
// one cell per transfer, in cell order, with last_cell set on the final cell.
// Only the final cell produces a result on the output channel
// (out_valid/out_ready/out_data): the balancing decision, the three bleed
// bytes for the balance registers and whether they must be written.
// Throughput: one cell per cycle unless a final cell waits (see below); the
// input register feeds a single compare and update step whose outcome lands
// in the output register, from which the result is offered.
// When the receiver stalls, the result is held in the output register and
// cells that do not end a scan keep flowing; a final cell waits in the input
// register until the output register is free.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are expected only while no scan is in progress.
// Synchronous reset empties both registers, restarts the scan, clears the
// stored mask and loads threshold 30 mV and floor 3000 mV.
module cell_balance_selector #(
  parameter int unsigned NUM_CELLS = cbs_pkg::NUM_CELLS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cbs_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cbs_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [cbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbs_pkg::MV_W-1:0]      cfg_data
);

  logic                     s1_valid;
  cbs_pkg::in_item_t        s1_item;
  logic                     s1_go;
  logic                     res_free;
  cbs_pkg::out_item_t       result;
  logic [cbs_pkg::MV_W-1:0] spread_threshold_mv;
  logic [cbs_pkg::MV_W-1:0] min_cell_floor_mv;

  // A final cell needs a free output register; other cells always move on.
  assign res_free = !out_valid || out_ready;
  assign s1_go    = s1_valid && (!s1_item.last_cell || res_free);
  assign in_ready = !s1_valid || s1_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      spread_threshold_mv <= cbs_pkg::SPREAD_THRESHOLD_RESET;
      min_cell_floor_mv   <= cbs_pkg::MIN_CELL_FLOOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cbs_pkg::REG_SPREAD_THRESHOLD: spread_threshold_mv <= cfg_data;
        cbs_pkg::REG_MIN_CELL_FLOOR:   min_cell_floor_mv   <= cfg_data;
        default: ;
      endcase
    end
  end

  cbs_scan #(
    .NUM_CELLS (NUM_CELLS)
  ) u_scan (
    .clk                 (clk),
    .rst                 (rst),
    .take                (s1_go),
    .item                (s1_item),
    .spread_threshold_mv (spread_threshold_mv),
    .min_cell_floor_mv   (min_cell_floor_mv),
    .result              (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_item.last_cell) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item.last_cell) begin
      out_data <= result;
    end
  end

endmodule

@@ sv/cbs_checker.sv @@
// Port checker for the cell balance selector and its bind statement.
`include "cell_balance_selector_assert.svh"

module cbs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input cbs_pkg::in_item_t             in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input cbs_pkg::out_item_t            out_data
);

  logic [cbs_pkg::MASK_W-1:0] out_mask;
  logic [cbs_pkg::MASK_W-1:0] hot_mask;
  logic                       off_ok;
  logic                       on_ok;

  assign out_mask = {out_data.bal_high, out_data.bal_mid, out_data.bal_low};
  assign hot_mask = cbs_pkg::MASK_W'(1) << out_data.max_cell_index;
  assign off_ok   = out_data.write_regs && (out_mask == '0);
  assign on_ok    = out_mask == hot_mask;

  // A waiting cell stays offered and unchanged.
  `CBS_ASSERT(a_in_hold, clk, rst, in_valid && !in_ready |=> in_valid && $stable(in_data))

  // A stalled result stays offered and unchanged.
  `CBS_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // Balancing off always writes zero bytes.
  `CBS_ASSERT(a_off_clears, clk, rst, out_valid && !out_data.bal_enable |-> off_ok)

  // Balancing on bleeds exactly the reported highest cell.
  `CBS_ASSERT(a_on_one_hot, clk, rst, out_valid && out_data.bal_enable |-> on_ok)

  // No result is offered right after reset.
  `CBS_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid)

endmodule

bind cell_balance_selector cbs_checker u_cbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
